@@ sv/hsv_pkg.sv @@
package hsv_pkg;

    // Fraction bits of hue, saturation and value
    localparam int FRAC_BITS = 16;
    localparam int QW        = FRAC_BITS + 1;
    // Divider operand width: largest divisor is 6 * 255
    localparam int DIVW      = 11;
    // Signed width for offset sums
    localparam int SUMW      = (FRAC_BITS >= 16) ? FRAC_BITS + 4 : 20;
    // Shifts from the 2^-16 register scale to the working scale
    localparam int SCL_L     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SCL_R     = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
    localparam int MULW      = 2 * QW;
    // Value scaling: 2^FRAC_BITS = 255 * VAL_Q + VAL_R
    localparam int VAL_Q     = (1 << FRAC_BITS) / 255;
    localparam int VAL_R     = (1 << FRAC_BITS) % 255;

    localparam logic [FRAC_BITS:0] UNIT = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [SUMW-1:0] UNIT_S = {{(SUMW-FRAC_BITS-1){1'b0}}, UNIT};

    // Register indexes
    localparam logic [1:0] CFG_HUE_SHIFT = 2'd0;
    localparam logic [1:0] CFG_SAT_OFS   = 2'd1;
    localparam logic [1:0] CFG_VAL_OFS   = 2'd2;

    // Hue sectors
    localparam logic [2:0] SECT_RY = 3'd0;
    localparam logic [2:0] SECT_YG = 3'd1;
    localparam logic [2:0] SECT_GC = 3'd2;
    localparam logic [2:0] SECT_CB = 3'd3;
    localparam logic [2:0] SECT_BM = 3'd4;

    typedef struct packed {
        logic [DIVW-1:0] rem;
        logic [DIVW-1:0] den;
        logic [QW-1:0]   quo;
    } t_div_lane;

    typedef struct packed {
        t_div_lane     h;
        t_div_lane     s;
        logic [QW-1:0] v;
        logic [7:0]    alpha;
    } t_div_stage;

    // One restoring division step; the first step yields the integer bit
    function automatic t_div_lane div_step(t_div_lane l, logic first);
        logic [DIVW:0] trial;
        t_div_lane     o;
        trial = first ? {1'b0, l.rem} : {l.rem, 1'b0};
        o = l;
        if (trial >= {1'b0, l.den}) begin
            o.rem = DIVW'(trial - {1'b0, l.den});
            o.quo = {l.quo[QW-2:0], 1'b1};
        end else begin
            o.rem = trial[DIVW-1:0];
            o.quo = {l.quo[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    // Floor of max * 2^FRAC_BITS / 255: whole multiples of 255 times VAL_Q,
    // then the leftover VAL_R share divided by 255 with a shift-and-add
    function automatic logic [FRAC_BITS:0] val_frac(logic [7:0] m);
        logic [15:0]          y;
        logic [16:0]          yq;
        logic [FRAC_BITS+8:0] w;
        y  = 16'(m * VAL_R);
        yq = {1'b0, y} + {9'd0, y[15:8]} + 17'd1;
        w  = (FRAC_BITS+9)'(m) * (FRAC_BITS+9)'(VAL_Q) + {{FRAC_BITS{1'b0}}, yq[16:8]};
        return w[FRAC_BITS:0];
    endfunction

    function automatic logic [FRAC_BITS-1:0] hue_to_frac(logic [15:0] hs);
        logic [FRAC_BITS+15:0] w;
        w = ((FRAC_BITS+16)'(hs) << SCL_L) >> SCL_R;
        return w[FRAC_BITS-1:0];
    endfunction

    // Floor scaling of a signed offset
    function automatic logic signed [SUMW-1:0] off_to_frac(logic signed [17:0] raw);
        logic signed [SUMW-1:0] x;
        x = SUMW'(raw);
        x = (x <<< SCL_L) >>> SCL_R;
        return x;
    endfunction

    function automatic logic [FRAC_BITS:0] clamp_unit(logic signed [SUMW-1:0] x);
        if (x < 0) begin
            return '0;
        end else if (x > UNIT_S) begin
            return UNIT;
        end
        return x[FRAC_BITS:0];
    endfunction

    // Truncation of x * 255.999999
    function automatic logic [7:0] to_chan(logic [FRAC_BITS:0] x);
        logic [FRAC_BITS+8:0] w;
        w = {x, 8'd0} - (FRAC_BITS+9)'(1);
        return (x == '0) ? 8'd0 : w[FRAC_BITS+7:FRAC_BITS];
    endfunction

endpackage

@@ sv/hsv_pix_in_if.sv @@
interface hsv_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

@@ sv/hsv_pix_out_if.sv @@
interface hsv_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

@@ sv/hsv_pixel_adjust_unit.sv @@
// Channel   Dir  Handshake      Payload
// i_pix     in   valid/ready    red_in, green_in, blue_in, alpha_in (8 bit each)
// o_pix     out  valid/ready    red_out, green_out, blue_out, alpha_out (8 bit each)
// i_cfg_*   in   write enable   index 0 hue shift, 1 saturation offset, 2 value offset
//
// One item per cycle while the output is not stalled; hue and saturation are
// formed by the bit-per-stage divider.
// Synchronous active-low reset clears stage valid bits and the configuration registers.
// A stalled output freezes every stage together; ready follows the output stage.
module hsv_pixel_adjust_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [17:0]           i_cfg_data,
    hsv_pix_in_if.sink            i_pix,
    hsv_pix_out_if.source         o_pix
);
    import hsv_pkg::*;

    logic en;

    // Configuration registers
    logic [15:0]        r_hue_shift;
    logic signed [17:0] r_sat_ofs;
    logic signed [17:0] r_val_ofs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_shift <= '0;
            r_sat_ofs   <= '0;
            r_val_ofs   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HUE_SHIFT: r_hue_shift <= i_cfg_data[15:0];
                CFG_SAT_OFS:   r_sat_ofs   <= $signed(i_cfg_data);
                CFG_VAL_OFS:   r_val_ofs   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Front stage: max, min, hue numerator and value
    logic [7:0]         r8, g8, b8, mx, mn, d;
    logic signed [8:0]  diff;
    logic [10:0]        bd, d6;
    logic signed [12:0] n;
    t_div_stage         n_s1, r_s1;
    logic               r_s1_vld;

    always_comb begin
        r8 = i_pix.red_in;
        g8 = i_pix.green_in;
        b8 = i_pix.blue_in;
        if (b8 >= g8 && b8 >= r8) begin
            mx   = b8;
            mn   = (r8 < g8) ? r8 : g8;
            diff = $signed({1'b0, r8}) - $signed({1'b0, g8});
        end else if (g8 >= r8) begin
            mx   = g8;
            mn   = (b8 < r8) ? b8 : r8;
            diff = $signed({1'b0, b8}) - $signed({1'b0, r8});
        end else begin
            mx   = r8;
            mn   = (g8 < b8) ? g8 : b8;
            diff = $signed({1'b0, g8}) - $signed({1'b0, b8});
        end
        d  = mx - mn;
        d6 = ({3'd0, d} << 2) + ({3'd0, d} << 1);
        if (b8 >= g8 && b8 >= r8) begin
            bd = {3'd0, d} << 2;
        end else if (g8 >= r8) begin
            bd = {3'd0, d} << 1;
        end else begin
            bd = '0;
        end
        n = $signed({2'b00, bd}) + 13'(diff);
        if (n < 0) begin
            n = n + $signed({2'b00, d6});
        end
        // Grey pixels divide zero by one
        n_s1.h.rem = (d == '0) ? '0 : n[DIVW-1:0];
        n_s1.h.den = (d == '0) ? DIVW'(1) : d6;
        n_s1.h.quo = '0;
        n_s1.s.rem = DIVW'(d);
        n_s1.s.den = (d == '0) ? DIVW'(1) : DIVW'(mx);
        n_s1.s.quo = '0;
        n_s1.v     = val_frac(mx);
        n_s1.alpha = i_pix.alpha_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
        end
    end

    // Divider: one quotient bit per stage; value rides along
    t_div_stage r_div     [0:FRAC_BITS];
    logic       r_div_vld [0:FRAC_BITS];

    for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_div
        t_div_stage src;
        logic       src_vld;
        if (k == 0) begin : g_first
            assign src     = r_s1;
            assign src_vld = r_s1_vld;
        end else begin : g_next
            assign src     = r_div[k-1];
            assign src_vld = r_div_vld[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_vld[k] <= 1'b0;
            end else if (en) begin
                r_div_vld[k] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div[k].h     <= div_step(src.h, k == 0);
                r_div[k].s     <= div_step(src.s, k == 0);
                r_div[k].v     <= src.v;
                r_div[k].alpha <= src.alpha;
            end
        end
    end

    t_div_stage dq;
    assign dq = r_div[FRAC_BITS];

    // Stage A: rotate hue, offset and clamp saturation and value
    logic [FRAC_BITS-1:0] r_a_h;
    logic [FRAC_BITS:0]   r_a_s, r_a_v;
    logic [7:0]           r_a_alpha;
    logic                 r_a_vld;
    logic [FRAC_BITS-1:0] n_a_h;
    logic signed [SUMW-1:0] sum_s, sum_v;

    always_comb begin
        n_a_h = dq.h.quo[FRAC_BITS-1:0] + hue_to_frac(r_hue_shift);
        sum_s = $signed({{(SUMW-FRAC_BITS-1){1'b0}}, dq.s.quo}) + off_to_frac(r_sat_ofs);
        sum_v = $signed({{(SUMW-FRAC_BITS-1){1'b0}}, dq.v}) + off_to_frac(r_val_ofs);
    end

    // Stage B: sector, t * s and v * (1 - s)
    logic [2:0]           r_b_sect;
    logic [MULW-1:0]      r_b_ts, r_b_pm;
    logic [FRAC_BITS:0]   r_b_v;
    logic [7:0]           r_b_alpha;
    logic                 r_b_vld;
    logic [FRAC_BITS+2:0] x6;
    logic [FRAC_BITS:0]   t_f;

    always_comb begin
        x6 = ({3'd0, r_a_h} << 2) + ({3'd0, r_a_h} << 1);
        if (x6[FRAC_BITS]) begin
            t_f = {1'b0, x6[FRAC_BITS-1:0]};
        end else begin
            t_f = UNIT - {1'b0, x6[FRAC_BITS-1:0]};
        end
    end

    // Stage C: p and 1 - t*s
    logic [2:0]         r_c_sect;
    logic [FRAC_BITS:0] r_c_p, r_c_u, r_c_v;
    logic [7:0]         r_c_alpha;
    logic               r_c_vld;

    // Stage D: v * u
    logic [2:0]         r_d_sect;
    logic [MULW-1:0]    r_d_qm;
    logic [FRAC_BITS:0] r_d_p, r_d_v;
    logic [7:0]         r_d_alpha;
    logic               r_d_vld;

    // Output stage
    logic [7:0] r_o_red, r_o_green, r_o_blue, r_o_alpha;
    logic       r_o_vld;
    logic [7:0] vo, po, qo;
    logic [7:0] n_red, n_green, n_blue;

    always_comb begin
        vo = to_chan(r_d_v);
        po = to_chan(r_d_p);
        qo = to_chan(r_d_qm[2*FRAC_BITS:FRAC_BITS]);
        unique case (r_d_sect)
            SECT_RY: begin n_red = vo; n_green = qo; n_blue = po; end
            SECT_YG: begin n_red = qo; n_green = vo; n_blue = po; end
            SECT_GC: begin n_red = po; n_green = vo; n_blue = qo; end
            SECT_CB: begin n_red = po; n_green = qo; n_blue = vo; end
            SECT_BM: begin n_red = qo; n_green = po; n_blue = vo; end
            default: begin n_red = vo; n_green = po; n_blue = qo; end
        endcase
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= r_div_vld[FRAC_BITS];
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_o_vld <= r_d_vld;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_h     <= n_a_h;
            r_a_s     <= clamp_unit(sum_s);
            r_a_v     <= clamp_unit(sum_v);
            r_a_alpha <= dq.alpha;

            r_b_sect  <= x6[FRAC_BITS+2:FRAC_BITS];
            r_b_ts    <= MULW'(t_f * r_a_s);
            r_b_pm    <= MULW'(r_a_v * (UNIT - r_a_s));
            r_b_v     <= r_a_v;
            r_b_alpha <= r_a_alpha;

            r_c_sect  <= r_b_sect;
            r_c_p     <= r_b_pm[2*FRAC_BITS:FRAC_BITS];
            r_c_u     <= UNIT - r_b_ts[2*FRAC_BITS:FRAC_BITS];
            r_c_v     <= r_b_v;
            r_c_alpha <= r_b_alpha;

            r_d_sect  <= r_c_sect;
            r_d_qm    <= MULW'(r_c_v * r_c_u);
            r_d_p     <= r_c_p;
            r_d_v     <= r_c_v;
            r_d_alpha <= r_c_alpha;

            r_o_red   <= n_red;
            r_o_green <= n_green;
            r_o_blue  <= n_blue;
            r_o_alpha <= r_d_alpha;
        end
    end

    // Hold every stage while the output item waits
    assign en          = !r_o_vld || o_pix.ready;
    assign i_pix.ready = en;

    assign o_pix.valid     = r_o_vld;
    assign o_pix.red_out   = r_o_red;
    assign o_pix.green_out = r_o_green;
    assign o_pix.blue_out  = r_o_blue;
    assign o_pix.alpha_out = r_o_alpha;

endmodule
